### design/mrg_pkg.sv
// ----------------------------------------------------------------------------
// mrg_pkg
// Shared constants, types and coefficient tables of the multi-stream
// combined recursive generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mrg_pkg;

    localparam int STREAMS    = 64;
    localparam int STRM_W     = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int CNT_W      = $clog2(STREAMS + 1);
    localparam int STREAM_FW  = 6;
    localparam int COUNT_FW   = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int FIFO_DEPTH = 2;

    typedef logic [31:0] t_word;

    localparam t_word MOD1 = 32'd4294967087;
    localparam t_word MOD2 = 32'd4294944443;
    // 2^32 minus each modulus, used to fold the upper bits back down.
    localparam logic [14:0] FOLD1 = 15'd209;
    localparam logic [14:0] FOLD2 = 15'd22853;

    localparam t_word A1 = 32'd1403580;
    localparam t_word B1 = 32'd810728;
    localparam t_word A2 = 32'd527612;
    localparam t_word B2 = 32'd1370589;

    localparam logic [CFG_IDX_W-1:0] REG_SEED  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REINIT = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_NOINIT = 2'd3;

    localparam logic [1:0] K_DRAW   = 2'd0;
    localparam logic [1:0] K_REINIT = 2'd1;
    localparam logic [1:0] K_RANGE  = 2'd2;
    localparam logic [1:0] K_NOINIT = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [STRM_W-1:0] stream;
        logic [CNT_W-1:0]  cnt;
    } t_cmd;

    // Jump-ahead matrices by 2^127 steps, selected by component, row, column.
    function automatic t_word jump_coef(input logic c, input logic [1:0] i,
                                        input logic [1:0] k);
        t_word v;
        v = '0;
        case ({c, i, k})
            5'b0_00_00: v = 32'd2427906178;
            5'b0_00_01: v = 32'd3580155704;
            5'b0_00_10: v = 32'd949770784;
            5'b0_01_00: v = 32'd226153695;
            5'b0_01_01: v = 32'd1230515664;
            5'b0_01_10: v = 32'd3580155704;
            5'b0_10_00: v = 32'd1988835001;
            5'b0_10_01: v = 32'd986791581;
            5'b0_10_10: v = 32'd1230515664;
            5'b1_00_00: v = 32'd1464411153;
            5'b1_00_01: v = 32'd277697599;
            5'b1_00_10: v = 32'd1610723613;
            5'b1_01_00: v = 32'd32183930;
            5'b1_01_01: v = 32'd1464411153;
            5'b1_01_10: v = 32'd1022607788;
            5'b1_10_00: v = 32'd2824425944;
            5'b1_10_01: v = 32'd32183930;
            5'b1_10_10: v = 32'd2093834863;
            default:    v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### design/mrg_ifs.sv
// ----------------------------------------------------------------------------
// mrg channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrg_req_if;
    import mrg_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [STREAM_FW-1:0] stream;
    modport source (output valid, func, stream, input ready);
    modport sink   (input valid, func, stream, output ready);
endinterface

interface mrg_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [1:0]  status;
    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

interface mrg_cfg_if;
    import mrg_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/mrg_fifo.sv
// ----------------------------------------------------------------------------
// mrg_fifo
// Short command queue between the classifying front and the execution back.
// ----------------------------------------------------------------------------
`default_nettype none

module mrg_fifo import mrg_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_din,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_dout,
    output logic      o_empty
);
    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCW   = $clog2(FIFO_DEPTH + 1);

    t_cmd             r_buf [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [FCW-1:0]   r_fill;

    assign o_full  = (r_fill == FCW'(FIFO_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_dout  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("command pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command popped from an empty queue");

endmodule

`default_nettype wire

### design/mrg_front.sv
// ----------------------------------------------------------------------------
// mrg_front
// Accepts requests, tracks initialization and the active stream count,
// and classifies each request into a queue command.
// ----------------------------------------------------------------------------
`default_nettype none

module mrg_front import mrg_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic                 i_func,
    input  wire logic [STREAM_FW-1:0] i_stream,
    input  wire logic [COUNT_FW-1:0]  i_count,
    input  wire logic                 i_full,
    output logic                      o_ready,
    output logic                      o_push,
    output t_cmd                      o_cmd
);
    logic             r_init;
    logic [CNT_W-1:0] r_active;
    logic [CNT_W-1:0] n_cnt;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // The requested count saturates into one to the number of streams.
    always_comb begin
        if (i_count == '0) begin
            n_cnt = CNT_W'(1);
        end else if (32'(i_count) > STREAMS) begin
            n_cnt = CNT_W'(STREAMS);
        end else begin
            n_cnt = CNT_W'(i_count);
        end
    end

    always_comb begin
        o_cmd.stream = STRM_W'(i_stream);
        o_cmd.cnt    = n_cnt;
        if (i_func) begin
            o_cmd.kind = K_REINIT;
        end else if (!r_init) begin
            o_cmd.kind = K_NOINIT;
        end else if (32'(i_stream) >= 32'(r_active) || 32'(i_stream) >= STREAMS) begin
            o_cmd.kind = K_RANGE;
        end else begin
            o_cmd.kind = K_DRAW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init   <= 1'b0;
            r_active <= '0;
        end else if (o_push && i_func) begin
            r_init   <= 1'b1;
            r_active <= n_cnt;
        end
    end

endmodule

`default_nettype wire

### design/mrg_back.sv
// ----------------------------------------------------------------------------
// mrg_back
// Executes queued commands: stream memory, a shared multiplier with an
// iterative modular reduction, and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrg_back import mrg_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_empty,
    input  t_cmd             i_cmd,
    input  wire logic [31:0] i_seed,
    input  wire logic        i_out_ready,
    output logic             o_pop,
    output logic             o_valid,
    output logic [31:0]      o_value,
    output logic [1:0]       o_status
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_LD   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_RED  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_WR   = 3'd7;

    localparam logic M_DRAW = 1'b0;
    localparam logic M_JUMP = 1'b1;

    logic [2:0]              r_state;
    logic                    r_mode;
    logic                    r_c;
    logic [1:0]              r_i;
    logic [1:0]              r_k;
    logic [STRM_W-1:0]       r_idx;
    logic [STRM_W-1:0]       r_stream;
    logic [CNT_W-1:0]        r_cnt;
    logic [2:0][31:0]        r_w1;
    logic [2:0][31:0]        r_w2;
    logic [1:0][2:0][31:0]   r_res;
    logic [63:0]             r_prod;
    logic [65:0]             r_acc;
    logic                    r_ovld;
    logic [31:0]             r_oval;
    logic [1:0]              r_ost;
    logic [191:0]            r_mem [STREAMS];
    logic [191:0]            r_rdata;

    t_word        mod_m;
    logic [14:0]  fold;
    t_word        x_sel;
    t_word        y_sel;
    t_word        y_red;
    t_word        neg;
    t_word        op_a;
    t_word        op_b;
    logic         last_k;
    logic [65:0]  red_next;
    t_word        fin_val;
    t_word        p1;
    t_word        p2;
    t_word        z;
    logic         mem_we;
    logic [STRM_W-1:0] mem_addr;
    logic [191:0] mem_wdata;
    logic         row_last;

    assign o_valid  = r_ovld;
    assign o_value  = r_oval;
    assign o_status = r_ost;
    assign o_pop    = (r_state == S_IDLE) && !i_empty && !r_ovld;

    always_comb begin
        mod_m  = r_c ? MOD2 : MOD1;
        fold   = r_c ? FOLD2 : FOLD1;
        x_sel  = r_c ? r_w2[2] : r_w1[1];
        y_sel  = r_c ? r_w2[0] : r_w1[0];
        y_red  = (y_sel >= mod_m) ? (y_sel - mod_m) : y_sel;
        neg    = mod_m - y_red;
        if (r_mode == M_DRAW) begin
            op_a   = (r_k == 2'd0) ? (r_c ? A2 : A1) : (r_c ? B2 : B1);
            op_b   = (r_k == 2'd0) ? x_sel : neg;
            last_k = (r_k == 2'd1);
        end else begin
            op_a   = jump_coef(r_c, r_i, r_k);
            op_b   = r_c ? r_w2[r_k] : r_w1[r_k];
            last_k = (r_k == 2'd2);
        end
        // One fold step: 2^32 is congruent to 2^32 - m.
        red_next = 66'(r_acc[65:32] * fold) + 66'(r_acc[31:0]);
        fin_val  = (r_acc[31:0] >= mod_m) ? (r_acc[31:0] - mod_m) : r_acc[31:0];
        p1       = r_res[0][0];
        p2       = r_res[1][0];
        z        = (p1 > p2) ? (p1 - p2) : 32'(33'(p1) + 33'(MOD1) - 33'(p2));
        row_last = ((CNT_W'(r_idx) + 1'b1) == r_cnt);
    end

    always_comb begin
        mem_we    = (r_state == S_WR);
        mem_addr  = (r_mode == M_DRAW) ? r_stream : r_idx;
        mem_wdata = (r_mode == M_DRAW)
                  ? {p2, r_w2[2], r_w2[1], p1, r_w1[2], r_w1[1]}
                  : {r_w2, r_w1};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_stream];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            if (r_ovld && i_out_ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        unique case (i_cmd.kind)
                            K_DRAW: begin
                                r_mode   <= M_DRAW;
                                r_stream <= i_cmd.stream;
                                r_state  <= S_RD;
                            end
                            K_REINIT: begin
                                r_mode  <= M_JUMP;
                                r_w1    <= {3{i_seed}};
                                r_w2    <= {3{i_seed}};
                                r_idx   <= '0;
                                r_cnt   <= i_cmd.cnt;
                                r_state <= S_WR;
                            end
                            K_RANGE: begin
                                r_ovld <= 1'b1;
                                r_oval <= '0;
                                r_ost  <= ST_RANGE;
                            end
                            K_NOINIT: begin
                                r_ovld <= 1'b1;
                                r_oval <= '0;
                                r_ost  <= ST_NOINIT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_LD;
                end
                S_LD: begin
                    r_w1    <= r_rdata[95:0];
                    r_w2    <= r_rdata[191:96];
                    r_c     <= 1'b0;
                    r_i     <= 2'd0;
                    r_k     <= 2'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= op_a * op_b;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= ((r_k == 2'd0) ? 66'd0 : r_acc) + 66'(r_prod);
                    if (last_k) begin
                        r_state <= S_RED;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_RED: begin
                    if (r_acc[65:32] != '0) begin
                        r_acc <= red_next;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_res[r_c][r_i] <= fin_val;
                    r_k <= 2'd0;
                    if (r_mode == M_DRAW) begin
                        if (!r_c) begin
                            r_c     <= 1'b1;
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_WR;
                        end
                    end else if (r_i != 2'd2) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_MUL;
                    end else if (!r_c) begin
                        r_c     <= 1'b1;
                        r_i     <= 2'd0;
                        r_state <= S_MUL;
                    end else begin
                        // The last word of the second component lands here.
                        r_w1    <= r_res[0];
                        r_w2    <= {fin_val, r_res[1][1], r_res[1][0]};
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if (r_mode == M_DRAW) begin
                        r_ovld  <= 1'b1;
                        r_oval  <= z;
                        r_ost   <= ST_OK;
                        r_state <= S_IDLE;
                    end else if (row_last) begin
                        r_ovld  <= 1'b1;
                        r_oval  <= '0;
                        r_ost   <= ST_REINIT;
                        r_state <= S_IDLE;
                    end else begin
                        r_c     <= 1'b0;
                        r_i     <= 2'd0;
                        r_k     <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_ost != ST_OK) |-> (r_oval == '0))
        else $error("non-draw response carries a nonzero value");
    a_draw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_ost == ST_OK) |-> (r_oval != '0 && r_oval <= MOD1))
        else $error("draw value outside one to the first modulus");
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR && r_mode == M_JUMP) |-> (CNT_W'(r_idx) < r_cnt))
        else $error("reinitialization wrote past the stream count");

endmodule

`default_nettype wire

### design/multi_stream_combined_mrg.sv
// ----------------------------------------------------------------------------
// multi_stream_combined_mrg
// Multi-stream combined recursive generator with stream state memory.
// ----------------------------------------------------------------------------
// i_req carries func and stream. A draw (func 0) advances the named stream
// and answers on o_rsp with value 1..4294967087 and status 0. A reinitialize
// (func 1) seeds stream 0 from the seed register and fills each further
// stream, up to streams_in_use, with the 2^127-step jump of the one before;
// it answers value 0, status 1. Draws before any reinitialize give status 3,
// draws to an unset stream give status 2, both with value 0.
// i_cfg writes register 0 (seed) or 1 (streams_in_use) and is always ready.
// Requests are classified on entry and queued two deep, so i_req keeps
// accepting while a response waits in the output register.
// A draw and a reinitialize both run through the single 32x32 multiplier,
// whose products are summed and then reduced by the iterative modular fold;
// a reinitialize repeats this for each stream after the first. One command
// runs at a time.
// After reset no stream is initialized and the registers hold 12345 and 64.
// When o_rsp stalls the response holds and the back end waits; the queue
// then fills and i_req.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_stream_combined_mrg import mrg_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mrg_req_if.sink    i_req,
    mrg_rsp_if.source  o_rsp,
    mrg_cfg_if.sink    i_cfg
);
    logic [31:0]         r_seed;
    logic [COUNT_FW-1:0] r_count;
    logic                push;
    logic                pop;
    logic                full;
    logic                empty;
    t_cmd                cmd_in;
    t_cmd                cmd_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= 32'd12345;
            r_count <= COUNT_FW'(64);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SEED:  r_seed  <= i_cfg.data;
                REG_COUNT: r_count <= i_cfg.data[COUNT_FW-1:0];
                default:   r_seed  <= r_seed;
            endcase
        end
    end

    mrg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_req.valid),
        .i_func   (i_req.func),
        .i_stream (i_req.stream),
        .i_count  (r_count),
        .i_full   (full),
        .o_ready  (i_req.ready),
        .o_push   (push),
        .o_cmd    (cmd_in)
    );

    mrg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_dout  (cmd_out),
        .o_empty (empty)
    );

    mrg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_cmd       (cmd_out),
        .i_seed      (r_seed),
        .i_out_ready (o_rsp.ready),
        .o_pop       (pop),
        .o_valid     (o_rsp.valid),
        .o_value     (o_rsp.value),
        .o_status    (o_rsp.status)
    );

endmodule

`default_nettype wire

### bench/tb_multi_stream_combined_mrg.sv
// ----------------------------------------------------------------------------
// tb_multi_stream_combined_mrg
// Self-checking bench for the multi-stream combined recursive generator.
// Requests and response back-pressure are driven with random gaps; register
// writes are made between phases. An in-bench model of the stream memory predicts every
// response, and each response is checked in order against that prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multi_stream_combined_mrg;
    import mrg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ITEMS   = 1800;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 40;

    typedef longint unsigned t_wide;

    // 2^127-step jump matrices of the two component recurrences.
    localparam t_wide JMP1 [3][3] = '{
        '{64'd2427906178, 64'd3580155704, 64'd949770784},
        '{64'd226153695,  64'd1230515664, 64'd3580155704},
        '{64'd1988835001, 64'd986791581,  64'd1230515664}};
    localparam t_wide JMP2 [3][3] = '{
        '{64'd1464411153, 64'd277697599,  64'd1610723613},
        '{64'd32183930,   64'd1464411153, 64'd1022607788},
        '{64'd2824425944, 64'd32183930,   64'd2093834863}};

    typedef struct {
        t_word      value;
        logic [1:0] status;
    } t_draw_rsp;

    class MrgScoreboard;
        t_word       comp1 [3*STREAMS];
        t_word       comp2 [3*STREAMS];
        bit          seeded;
        int unsigned live_streams;
        t_word       seed_reg;
        logic [6:0]  count_reg;
        t_draw_rsp   expected_q[$];
        int          mismatches;

        function new();
            seeded       = 0;
            live_streams = 0;
            seed_reg     = 32'd12345;
            count_reg    = 7'd64;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, t_word data);
            if (idx == REG_SEED)
                seed_reg = data;
            else
                count_reg = data[6:0];
        endfunction

        // (a*x + b*(m - y)) mod m with both words reduced first.
        function t_wide recur_mod(t_wide a, t_wide x, t_wide b, t_wide y, t_wide m);
            t_wide neg;
            neg = m - (y % m);
            return (a * (x % m) + b * neg) % m;
        endfunction

        function void jump_words(ref t_wide w[3], input bit second, input t_wide m);
            t_wide r [3];
            t_wide acc;
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += (w[k] * (second ? JMP2[i][k] : JMP1[i][k])) % m;
                r[i] = acc % m;
            end
            w = r;
        endfunction

        function void note_request(bit func, logic [5:0] s);
            t_draw_rsp e;
            t_wide     w1 [3];
            t_wide     w2 [3];
            t_wide     m1, m2, p1, p2;
            int unsigned cnt, b;
            m1 = MOD1;
            m2 = MOD2;
            e.value = '0;
            if (func) begin
                cnt = count_reg;
                if (cnt < 1) cnt = 1;
                if (cnt > STREAMS) cnt = STREAMS;
                for (int k = 0; k < 3; k++) begin
                    w1[k] = seed_reg;
                    w2[k] = seed_reg;
                end
                for (int i = 0; i < cnt; i++) begin
                    for (int k = 0; k < 3; k++) begin
                        comp1[3*i+k] = w1[k][31:0];
                        comp2[3*i+k] = w2[k][31:0];
                    end
                    jump_words(w1, 1'b0, m1);
                    jump_words(w2, 1'b1, m2);
                end
                live_streams = cnt;
                seeded = 1;
                e.status = ST_REINIT;
            end else if (!seeded) begin
                e.status = ST_NOINIT;
            end else if (s >= live_streams) begin
                e.status = ST_RANGE;
            end else begin
                b  = 3 * s;
                p1 = recur_mod(64'd1403580, comp1[b+1], 64'd810728, comp1[b], m1);
                p2 = recur_mod(64'd527612, comp2[b+2], 64'd1370589, comp2[b], m2);
                comp1[b]   = comp1[b+1];
                comp1[b+1] = comp1[b+2];
                comp1[b+2] = p1[31:0];
                comp2[b]   = comp2[b+1];
                comp2[b+1] = comp2[b+2];
                comp2[b+2] = p2[31:0];
                e.value  = (p1 > p2) ? t_word'(p1 - p2) : t_word'(p1 + m1 - p2);
                e.status = ST_OK;
            end
            expected_q.push_back(e);
        endfunction

        function void check_response(t_word value, logic [1:0] status);
            t_draw_rsp e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat value=%0d status=%0d",
                             $realtime, value, status);
                return;
            end
            e = expected_q.pop_front();
            if (value !== e.value || status !== e.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected value=%0d status=%0d, got value=%0d status=%0d",
                             $realtime, e.value, e.status, value, status);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mrg_req_if req ();
    mrg_rsp_if rsp ();
    mrg_cfg_if cfg ();

    multi_stream_combined_mrg dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .i_cfg   (cfg)
    );

    MrgScoreboard sb = new();

    bit tx_quiet;
    bit rx_quiet;
    bit rx_hold_req;
    int sent;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #8ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Responses are checked before requests are noted; a request accepted on
    // this edge cannot have produced a response on the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                sb.check_response(rsp.value, rsp.status);
            if (req.valid === 1'b1 && req.ready === 1'b1)
                sb.note_request(req.func, req.stream);
        end
    end

    // Response side: a random pause before each beat, or one long hold-off.
    initial begin
        int gap;
        rsp.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 0;
                gap = LONG_HOLD;
            end else begin
                gap = rx_quiet ? 0 : $urandom_range(0, 6);
            end
            if (gap > 0) begin
                rsp.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            rsp.ready = 1'b1;
            do @(posedge i_clk); while (rsp.valid !== 1'b1);
        end
    end

    task automatic send_req(input bit f, input logic [5:0] s);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            req.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.valid  = 1'b1;
        req.func   = f;
        req.stream = s;
        do @(posedge i_clk); while (req.ready !== 1'b1);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_word data);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = data;
        do @(posedge i_clk); while (cfg.ready !== 1'b1);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        cfg.valid = 1'b0;
    endtask

    task automatic wait_idle();
        req.valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // One phase: new registers, a reinitialize, then mostly valid draws.
    task automatic run_phase(input int p);
        t_word       seed_val;
        t_word       cnt_word;
        int unsigned live, n, r;
        wait_idle();
        tx_quiet = (p == 3) || (p == 4);
        rx_quiet = (p == 3);
        case ($urandom_range(0, 7))
            0: seed_val = '0;
            1: seed_val = '1;
            2: seed_val = MOD2 - 1;
            3: seed_val = 32'd1;
            default: seed_val = $urandom;
        endcase
        cnt_word = $urandom;
        case ($urandom_range(0, 9))
            0: cnt_word[6:0] = 7'd64;
            1: cnt_word[6:0] = 7'd1;
            2: cnt_word[6:0] = 7'd0;
            3: cnt_word[6:0] = 7'($urandom_range(65, 127));
            default: cnt_word[6:0] = 7'($urandom_range(2, 16));
        endcase
        write_reg(REG_COUNT, cnt_word);
        write_reg(REG_SEED, seed_val);
        live = (cnt_word[6:0] == 0) ? 1 : (cnt_word[6:0] > STREAMS) ? STREAMS
                                                                    : cnt_word[6:0];
        send_req(1'b1, 6'($urandom));
        if (p == 2)
            rx_hold_req = 1;
        n = $urandom_range(80, 200);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 1)
                send_req(1'b1, 6'($urandom));
            else if (r < 86)
                send_req(1'b0, 6'($urandom_range(0, live - 1)));
            else
                send_req(1'b0, 6'($urandom));
        end
    endtask

    initial begin
        int p;
        i_rst_n     = 1'b0;
        req.valid   = 1'b0;
        req.func    = 1'b0;
        req.stream  = '0;
        cfg.valid   = 1'b0;
        cfg.index   = REG_SEED;
        cfg.data    = '0;
        tx_quiet    = 0;
        rx_quiet    = 0;
        rx_hold_req = 0;
        sent        = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Draws before any reinitialize are refused.
        send_req(1'b0, 6'd0);
        send_req(1'b0, 6'd63);
        // Reset register values: default seed over all 64 streams.
        send_req(1'b1, 6'd63);
        send_req(1'b0, 6'd0);
        send_req(1'b0, 6'd63);
        send_req(1'b0, 6'd0);
        wait_idle();
        // Single stream, smallest seed; stream 1 is then out of range.
        write_reg(REG_SEED, 32'd1);
        write_reg(REG_COUNT, 32'd1);
        send_req(1'b1, 6'd0);
        send_req(1'b0, 6'd0);
        send_req(1'b0, 6'd1);
        send_req(1'b0, 6'd63);
        wait_idle();
        // Zero seed gives the all-zero stream; count 0 acts as one stream.
        write_reg(REG_SEED, 32'd0);
        write_reg(REG_COUNT, 32'd0);
        send_req(1'b1, 6'd0);
        send_req(1'b0, 6'd0);
        send_req(1'b0, 6'd0);
        send_req(1'b0, 6'd1);
        wait_idle();
        // Seed above both moduli, count above the stream total.
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        write_reg(REG_COUNT, 32'hFFFF_FFFF);
        send_req(1'b1, 6'd5);
        send_req(1'b0, 6'd63);
        send_req(1'b0, 6'd0);
        wait_idle();
        write_reg(REG_SEED, MOD2 - 1);
        write_reg(REG_COUNT, 32'd2);
        send_req(1'b1, 6'd0);
        send_req(1'b0, 6'd1);
        send_req(1'b0, 6'd2);

        p = 0;
        while (sent < NUM_ITEMS) begin
            run_phase(p);
            p++;
        end
        tx_quiet = 0;
        rx_quiet = 0;

        req.valid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
